>>> hdl/acull_pkg.sv
// Shared types, constants and helpers for the box frustum culling pipeline.
// Depends on nothing; the hdl files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package acull_pkg;

    // Field and datapath widths.
    localparam int COORD_BITS  = 16;
    localparam int COEF_BITS   = 16;
    localparam int PROD_BITS   = COORD_BITS + COEF_BITS;
    localparam int CLIP_BITS   = PROD_BITS + 2;
    localparam int OC_BITS     = 6;
    localparam int NUM_AXES    = 3;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_CORNERS = 8;

    // Register file geometry: 64-bit rows at byte address 8*i.
    localparam int REG_BITS     = 64;
    localparam int ADDR_BITS    = 5;
    localparam int REG_SEL_LSB  = 3;
    localparam int REG_SEL_BITS = 2;

    // Matrix rows after reset: identity in Q4.12.
    localparam logic [REG_BITS-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [REG_BITS-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [REG_BITS-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [REG_BITS-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    // Clip-space rows.
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    // Outcode bit positions.
    localparam int OC_X_NEG  = 0;
    localparam int OC_X_POS  = 1;
    localparam int OC_Y_NEG  = 2;
    localparam int OC_Y_POS  = 3;
    localparam int OC_Z_FAR  = 4;
    localparam int OC_Z_NEAR = 5;

    // Verdict codes.
    localparam logic [1:0] VERDICT_INSIDE  = 2'd0;
    localparam logic [1:0] VERDICT_OUTSIDE = 2'd1;
    localparam logic [1:0] VERDICT_PARTIAL = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic [OC_BITS-1:0]           outcode_t;

    typedef logic [NUM_AXES-1:0][COORD_BITS-1:0]                coord_vec_t;
    typedef logic [NUM_ROWS-1:0][REG_BITS-1:0]                  matrix_t;
    typedef logic [NUM_ROWS-1:0][NUM_AXES-1:0][PROD_BITS-1:0]   prod_set_t;
    typedef logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][CLIP_BITS-1:0] clip_set_t;
    typedef logic [NUM_CORNERS-1:0][OC_BITS-1:0]                outcode_set_t;

    // Coefficient of row r, column c, as a signed Q4.12 value.
    function automatic coef_t coef_at(input matrix_t m, input int r, input int c);
        coef_at = $signed(m[r][c*COEF_BITS +: COEF_BITS]);
    endfunction

    // Whether corner k takes the maximum coordinate on the given axis.
    function automatic logic corner_uses_max(input int k, input int axis);
        logic sel;
        case (axis)
            0:       sel = ((k & 1) == 0);
            1:       sel = ((k & 4) != 0);
            default: sel = ((k & 2) != 0);
        endcase
        corner_uses_max = sel;
    endfunction

endpackage

`default_nettype wire

>>> hdl/aabb_frustum_cull.sv
// Path: a box accepted at a clock edge is registered in turn by the mul, sum,
// code and merge stages; its result is on the ports while done is high.
// Throughput: one box per cycle; 24 multipliers feed a fixed four-stage pipeline,
// busy stays low and the receiver takes every result in its one strobe cycle.
// Reset: rst_n clears all stage valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none

module aabb_frustum_cull (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [15:0]                min_x,
    input  wire logic signed [15:0]                min_y,
    input  wire logic signed [15:0]                min_z,
    input  wire logic signed [15:0]                max_x,
    input  wire logic signed [15:0]                max_y,
    input  wire logic signed [15:0]                max_z,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [acull_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [acull_pkg::REG_BITS-1:0]    pwdata,
    output logic      [acull_pkg::REG_BITS-1:0]    prdata,
    output logic                                   pready,
    output logic                                   done,
    output logic [1:0]                             verdict,
    output logic [5:0]                             common_outcode,
    output logic [5:0]                             union_outcode
);

    acull_pkg::matrix_t       matrix;
    acull_pkg::coord_vec_t    lo;
    acull_pkg::coord_vec_t    hi;
    acull_pkg::prod_set_t     prod_lo;
    acull_pkg::prod_set_t     prod_hi;
    acull_pkg::clip_set_t     clip;
    acull_pkg::outcode_set_t  codes;
    logic                     accept;
    logic                     mul_valid;
    logic                     sum_valid;
    logic                     code_valid;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Box corners gathered per axis.
    assign lo[0] = min_x;
    assign lo[1] = min_y;
    assign lo[2] = min_z;
    assign hi[0] = max_x;
    assign hi[1] = max_y;
    assign hi[2] = max_z;

    acull_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .matrix  (matrix)
    );

    acull_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .lo        (lo),
        .hi        (hi),
        .matrix    (matrix),
        .out_valid (mul_valid),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi)
    );

    acull_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi),
        .matrix    (matrix),
        .out_valid (sum_valid),
        .clip      (clip)
    );

    acull_code u_code (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .clip      (clip),
        .out_valid (code_valid),
        .codes     (codes)
    );

    acull_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (code_valid),
        .codes          (codes),
        .done           (done),
        .verdict        (verdict),
        .common_outcode (common_outcode),
        .union_outcode  (union_outcode)
    );

endmodule

`default_nettype wire

>>> hdl/acull_cfg.sv
// Register file for the four 64-bit matrix rows behind an APB-style port.
// Depends on acull_pkg for widths, reset values and the matrix type.
`timescale 1ns / 1ps
`default_nettype none

module acull_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [acull_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [acull_pkg::REG_BITS-1:0]    pwdata,
    output logic      [acull_pkg::REG_BITS-1:0]    prdata,
    output logic                                   pready,
    output acull_pkg::matrix_t                     matrix
);

    acull_pkg::matrix_t                       matrix_reg;
    acull_pkg::matrix_t                       matrix_next;
    logic [acull_pkg::REG_SEL_BITS-1:0]       reg_sel;
    logic                                     wr_en;

    assign reg_sel = paddr[acull_pkg::REG_SEL_LSB +: acull_pkg::REG_SEL_BITS];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    // Write decode: the selected row takes the write data.
    always_comb
    begin
        matrix_next = matrix_reg;
        if (wr_en)
        begin
            matrix_next[reg_sel] = pwdata;
        end
    end

    // Row storage, identity after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg[0] <= acull_pkg::ROW0_RESET;
            matrix_reg[1] <= acull_pkg::ROW1_RESET;
            matrix_reg[2] <= acull_pkg::ROW2_RESET;
            matrix_reg[3] <= acull_pkg::ROW3_RESET;
        end
        else
        begin
            matrix_reg <= matrix_next;
        end
    end

    assign prdata = matrix_reg[reg_sel];
    assign matrix = matrix_reg;

endmodule

`default_nettype wire

>>> hdl/acull_mul.sv
// First pipeline stage: the 24 coefficient-by-coordinate products.
// Depends on acull_pkg for widths, types and coefficient extraction.
`timescale 1ns / 1ps
`default_nettype none

module acull_mul (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire acull_pkg::coord_vec_t lo,
    input  wire acull_pkg::coord_vec_t hi,
    input  wire acull_pkg::matrix_t    matrix,
    output logic                       out_valid,
    output acull_pkg::prod_set_t       prod_lo,
    output acull_pkg::prod_set_t       prod_hi
);

    logic                  valid_reg;
    acull_pkg::prod_set_t  prod_lo_reg;
    acull_pkg::prod_set_t  prod_hi_reg;
    acull_pkg::prod_set_t  prod_lo_next;
    acull_pkg::prod_set_t  prod_hi_next;

    // Each matrix entry of the first three columns times the min and max
    // coordinate of its axis; corners share these products later.
    always_comb
    begin
        logic signed [acull_pkg::PROD_BITS-1:0] coef_ext;
        logic signed [acull_pkg::PROD_BITS-1:0] lo_ext;
        logic signed [acull_pkg::PROD_BITS-1:0] hi_ext;
        for (int r = 0; r < acull_pkg::NUM_ROWS; r++)
        begin
            for (int a = 0; a < acull_pkg::NUM_AXES; a++)
            begin
                coef_ext = acull_pkg::PROD_BITS'(acull_pkg::coef_at(matrix, r, a));
                lo_ext   = acull_pkg::PROD_BITS'($signed(lo[a]));
                hi_ext   = acull_pkg::PROD_BITS'($signed(hi[a]));
                prod_lo_next[r][a] = coef_ext * lo_ext;
                prod_hi_next[r][a] = coef_ext * hi_ext;
            end
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Product registers.
    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
    end

    assign out_valid = valid_reg;
    assign prod_lo   = prod_lo_reg;
    assign prod_hi   = prod_hi_reg;

endmodule

`default_nettype wire

>>> hdl/acull_sum.sv
// Second pipeline stage: clip coordinates of all eight corners.
// Depends on acull_pkg for widths, types and corner selection.
`timescale 1ns / 1ps
`default_nettype none

module acull_sum (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire acull_pkg::prod_set_t  prod_lo,
    input  wire acull_pkg::prod_set_t  prod_hi,
    input  wire acull_pkg::matrix_t    matrix,
    output logic                       out_valid,
    output acull_pkg::clip_set_t       clip
);

    logic                  valid_reg;
    acull_pkg::clip_set_t  clip_reg;
    acull_pkg::clip_set_t  clip_next;

    // Each clip value is the translation column plus the three products
    // picked by the corner's min/max pattern.
    always_comb
    begin
        logic signed [acull_pkg::CLIP_BITS-1:0] acc;
        logic signed [acull_pkg::PROD_BITS-1:0] term;
        for (int k = 0; k < acull_pkg::NUM_CORNERS; k++)
        begin
            for (int r = 0; r < acull_pkg::NUM_ROWS; r++)
            begin
                acc = acull_pkg::CLIP_BITS'(acull_pkg::coef_at(matrix, r, acull_pkg::NUM_AXES));
                for (int a = 0; a < acull_pkg::NUM_AXES; a++)
                begin
                    if (acull_pkg::corner_uses_max(k, a))
                    begin
                        term = $signed(prod_hi[r][a]);
                    end
                    else
                    begin
                        term = $signed(prod_lo[r][a]);
                    end
                    acc = acc + acull_pkg::CLIP_BITS'(term);
                end
                clip_next[k][r] = acc;
            end
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Clip value registers.
    always_ff @(posedge clk)
    begin
        clip_reg <= clip_next;
    end

    assign out_valid = valid_reg;
    assign clip      = clip_reg;

endmodule

`default_nettype wire

>>> hdl/acull_code.sv
// Third pipeline stage: one 6-bit outcode for each clipped corner.
// Depends on acull_pkg for widths, types and outcode bit positions.
`timescale 1ns / 1ps
`default_nettype none

module acull_code (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire acull_pkg::clip_set_t  clip,
    output logic                       out_valid,
    output acull_pkg::outcode_set_t    codes
);

    localparam int CMP_BITS = acull_pkg::CLIP_BITS + 1;

    logic                      valid_reg;
    acull_pkg::outcode_set_t   codes_reg;
    acull_pkg::outcode_set_t   codes_next;

    // Plane tests are done as signs of sums and differences against w,
    // one bit wider than the clip values so nothing can wrap.
    always_comb
    begin
        logic signed [CMP_BITS-1:0] x;
        logic signed [CMP_BITS-1:0] y;
        logic signed [CMP_BITS-1:0] z;
        logic signed [CMP_BITS-1:0] w;
        logic signed [CMP_BITS-1:0] x_plus_w;
        logic signed [CMP_BITS-1:0] w_minus_x;
        logic signed [CMP_BITS-1:0] y_plus_w;
        logic signed [CMP_BITS-1:0] w_minus_y;
        logic signed [CMP_BITS-1:0] w_minus_z;
        for (int k = 0; k < acull_pkg::NUM_CORNERS; k++)
        begin
            x = CMP_BITS'($signed(clip[k][acull_pkg::ROW_X]));
            y = CMP_BITS'($signed(clip[k][acull_pkg::ROW_Y]));
            z = CMP_BITS'($signed(clip[k][acull_pkg::ROW_Z]));
            w = CMP_BITS'($signed(clip[k][acull_pkg::ROW_W]));
            x_plus_w  = x + w;
            w_minus_x = w - x;
            y_plus_w  = y + w;
            w_minus_y = w - y;
            w_minus_z = w - z;
            codes_next[k][acull_pkg::OC_X_NEG]  = x_plus_w[CMP_BITS-1];
            codes_next[k][acull_pkg::OC_X_POS]  = w_minus_x[CMP_BITS-1];
            codes_next[k][acull_pkg::OC_Y_NEG]  = y_plus_w[CMP_BITS-1];
            codes_next[k][acull_pkg::OC_Y_POS]  = w_minus_y[CMP_BITS-1];
            codes_next[k][acull_pkg::OC_Z_FAR]  = w_minus_z[CMP_BITS-1];
            codes_next[k][acull_pkg::OC_Z_NEAR] = z[CMP_BITS-1];
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Outcode registers.
    always_ff @(posedge clk)
    begin
        codes_reg <= codes_next;
    end

    assign out_valid = valid_reg;
    assign codes     = codes_reg;

endmodule

`default_nettype wire

>>> hdl/acull_merge.sv
// Last pipeline stage: AND and OR of the corner outcodes and the verdict,
// held in the output registers. Depends on acull_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acull_merge (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire acull_pkg::outcode_set_t  codes,
    output logic                          done,
    output logic [1:0]                    verdict,
    output acull_pkg::outcode_t           common_outcode,
    output acull_pkg::outcode_t           union_outcode
);

    logic                  done_reg;
    logic [1:0]            verdict_reg;
    acull_pkg::outcode_t   common_reg;
    acull_pkg::outcode_t   union_reg;
    logic [1:0]            verdict_next;
    acull_pkg::outcode_t   common_next;
    acull_pkg::outcode_t   union_next;

    // Reduce the eight outcodes and classify the box.
    always_comb
    begin
        common_next = '1;
        union_next  = '0;
        for (int k = 0; k < acull_pkg::NUM_CORNERS; k++)
        begin
            common_next = common_next & codes[k];
            union_next  = union_next | codes[k];
        end
        if (union_next == '0)
        begin
            verdict_next = acull_pkg::VERDICT_INSIDE;
        end
        else if (common_next != '0)
        begin
            verdict_next = acull_pkg::VERDICT_OUTSIDE;
        end
        else
        begin
            verdict_next = acull_pkg::VERDICT_PARTIAL;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        common_reg  <= common_next;
        union_reg   <= union_next;
    end

    assign done           = done_reg;
    assign verdict        = verdict_reg;
    assign common_outcode = common_reg;
    assign union_outcode  = union_reg;

    // An item reaching this stage is shown in the very next cycle.
    a_valid_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> done_reg)
        else $error("item reached the last stage but no result strobe followed");

    // No strobe without an item behind it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> !done_reg)
        else $error("result strobe without an item");

    // Every bit common to all corners is also in the union.
    a_common_in_union: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((common_reg & ~union_reg) == '0))
        else $error("common outcode not contained in union outcode");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the box frustum culling block (aabb_frustum_cull).
// Depends on hdl/acull_pkg.sv for widths, matrix reset rows, outcode bits and verdicts.
`timescale 1ns / 1ps

module testbench;
    import acull_pkg::*;

    localparam int LATENCY         = 4;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int NUM_DIRECTED    = 21;

    localparam coord_t C_MIN = 16'sh8000;
    localparam coord_t C_MAX = 16'sh7FFF;
    localparam coord_t C_A5  = 16'sh5555;
    localparam coord_t C_5A  = 16'shAAAA;

    localparam outcode_t OCM_NONE   = '0;
    localparam outcode_t OCM_ALL    = '1;
    localparam outcode_t OCM_X_NEG  = outcode_t'(1 << OC_X_NEG);
    localparam outcode_t OCM_X_POS  = outcode_t'(1 << OC_X_POS);
    localparam outcode_t OCM_Y_NEG  = outcode_t'(1 << OC_Y_NEG);
    localparam outcode_t OCM_Y_POS  = outcode_t'(1 << OC_Y_POS);
    localparam outcode_t OCM_Z_FAR  = outcode_t'(1 << OC_Z_FAR);
    localparam outcode_t OCM_Z_NEAR = outcode_t'(1 << OC_Z_NEAR);

    // Matrices used by the directed rows.
    localparam matrix_t M_IDENT  = {ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};
    localparam matrix_t M_ZERO   = '0;
    localparam matrix_t M_ONES   = '1;
    localparam matrix_t M_MAXCOF = {4{64'h7FFF_7FFF_7FFF_7FFF}};
    localparam matrix_t M_MINCOF = {4{64'h8000_8000_8000_8000}};
    localparam matrix_t M_MIXED  = {64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                                    64'h0001_FFFF_8000_7FFF, 64'h7FFF_0001_FFFF_8000};

    localparam int             EXTREME_COORDS [5] = '{-32768, 32767, 0, -1, 1};
    localparam logic [15:0]    EXTREME_COEFS  [5] = '{16'h7FFF, 16'h8000, 16'h0000,
                                                      16'hFFFF, 16'h0001};

    typedef struct {
        coord_t min_x, min_y, min_z;
        coord_t max_x, max_y, max_z;
    } box_t;

    typedef struct packed {
        logic [1:0] verdict;
        outcode_t   common_oc;
        outcode_t   union_oc;
    } cull_result_t;

    // One directed row: optional matrix load, the box, and a typed verdict where obvious.
    typedef struct {
        bit           load;
        matrix_t      mat;
        box_t         box;
        bit           typed;
        cull_result_t want;
    } dir_row_t;

    // Directed table: identity matrix first, then degenerate and extreme matrices, then identity again.
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, M_IDENT, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}},
        '{1'b0, M_IDENT, '{-16'sd1, -16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd1},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}},
        '{1'b0, M_IDENT, '{16'sd2, 16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0},
          1'b1, '{VERDICT_OUTSIDE, OCM_X_POS, OCM_X_POS}},
        '{1'b0, M_IDENT, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
          1'b1, '{VERDICT_PARTIAL, OCM_NONE, OCM_ALL}},
        '{1'b0, M_IDENT, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
          1'b1, '{VERDICT_OUTSIDE, OCM_X_POS | OCM_Y_POS | OCM_Z_FAR,
                  OCM_X_POS | OCM_Y_POS | OCM_Z_FAR}},
        '{1'b0, M_IDENT, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
          1'b1, '{VERDICT_OUTSIDE, OCM_X_NEG | OCM_Y_NEG | OCM_Z_NEAR,
                  OCM_X_NEG | OCM_Y_NEG | OCM_Z_NEAR}},
        '{1'b0, M_IDENT, '{16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd0},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}},
        '{1'b0, M_IDENT, '{-16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, '{VERDICT_PARTIAL, OCM_NONE, OCM_X_NEG}},
        '{1'b0, M_IDENT, '{16'sd0, -16'sd5, 16'sd0, 16'sd0, -16'sd2, 16'sd0},
          1'b1, '{VERDICT_OUTSIDE, OCM_Y_NEG, OCM_Y_NEG}},
        '{1'b0, M_IDENT, '{16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd3, 16'sd0},
          1'b1, '{VERDICT_OUTSIDE, OCM_Y_POS, OCM_Y_POS}},
        '{1'b0, M_IDENT, '{16'sd0, 16'sd0, -16'sd3, 16'sd0, 16'sd0, -16'sd1},
          1'b1, '{VERDICT_OUTSIDE, OCM_Z_NEAR, OCM_Z_NEAR}},
        '{1'b0, M_IDENT, '{16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd9},
          1'b1, '{VERDICT_OUTSIDE, OCM_Z_FAR, OCM_Z_FAR}},
        '{1'b0, M_IDENT, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
          1'b1, '{VERDICT_OUTSIDE, OCM_Z_NEAR, OCM_Z_NEAR}},
        '{1'b0, M_IDENT, '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}},
        '{1'b0, M_IDENT, '{C_A5, C_5A, C_A5, C_5A, C_A5, C_5A},
          1'b0, '0},
        '{1'b1, M_ZERO, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}},
        '{1'b1, M_MAXCOF, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX},
          1'b0, '0},
        '{1'b1, M_MINCOF, '{C_5A, C_A5, C_5A, C_A5, C_5A, C_A5},
          1'b0, '0},
        '{1'b1, M_ONES, '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN},
          1'b0, '0},
        '{1'b1, M_MIXED, '{16'sd123, -16'sd456, 16'sd789, -16'sd1000, 16'sd2000, -16'sd3000},
          1'b0, '0},
        '{1'b1, M_IDENT, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, '{VERDICT_INSIDE, OCM_NONE, OCM_NONE}}
    };

    // Block ports.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    coord_t               min_x = '0;
    coord_t               min_y = '0;
    coord_t               min_z = '0;
    coord_t               max_x = '0;
    coord_t               max_y = '0;
    coord_t               max_z = '0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [REG_BITS-1:0]  pwdata = '0;
    logic [REG_BITS-1:0]  prdata;
    logic                 pready;
    logic                 done;
    logic [1:0]           verdict;
    logic [5:0]           common_outcode;
    logic [5:0]           union_outcode;

    // Scoreboard state.
    matrix_t      view_proj = M_IDENT;
    cull_result_t awaited_verdicts [$];
    bit           no_idle = 1'b0;
    int           mismatches = 0;
    int           boxes_sent = 0;
    int           results_checked = 0;
    int           matrix_loads = 0;
    int           stall_cycles = 0;
    int           inside_seen = 0;
    int           outside_seen = 0;
    int           partial_seen = 0;

    aabb_frustum_cull dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .min_x          (min_x),
        .min_y          (min_y),
        .min_z          (min_z),
        .max_x          (max_x),
        .max_y          (max_y),
        .max_z          (max_z),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .done           (done),
        .verdict        (verdict),
        .common_outcode (common_outcode),
        .union_outcode  (union_outcode)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transform all eight corners exactly and fold their outcodes into a verdict.
    function automatic cull_result_t cull_box(input matrix_t m, input box_t b);
        longint       pt [3];
        longint       clip [4];
        longint       coef;
        outcode_t     oc;
        outcode_t     and_oc;
        outcode_t     or_oc;
        cull_result_t res;
        and_oc = '1;
        or_oc  = '0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            pt[0] = k[0] ? b.max_x : b.min_x;
            pt[1] = k[1] ? b.max_y : b.min_y;
            pt[2] = k[2] ? b.max_z : b.min_z;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                // Column 3 multiplies w = 1, so it enters as the raw coefficient.
                coef    = $signed(m[r][COEF_BITS*3 +: COEF_BITS]);
                clip[r] = coef;
                for (int c = 0; c < NUM_AXES; c++)
                begin
                    coef    = $signed(m[r][COEF_BITS*c +: COEF_BITS]);
                    clip[r] = clip[r] + coef * pt[c];
                end
            end
            oc            = '0;
            oc[OC_X_NEG]  = clip[ROW_X] < -clip[ROW_W];
            oc[OC_X_POS]  = clip[ROW_X] > clip[ROW_W];
            oc[OC_Y_NEG]  = clip[ROW_Y] < -clip[ROW_W];
            oc[OC_Y_POS]  = clip[ROW_Y] > clip[ROW_W];
            oc[OC_Z_FAR]  = clip[ROW_Z] > clip[ROW_W];
            oc[OC_Z_NEAR] = clip[ROW_Z] < 0;
            and_oc        = and_oc & oc;
            or_oc         = or_oc | oc;
        end
        if (or_oc == '0)
            res.verdict = VERDICT_INSIDE;
        else if (and_oc != '0)
            res.verdict = VERDICT_OUTSIDE;
        else
            res.verdict = VERDICT_PARTIAL;
        res.common_oc = and_oc;
        res.union_oc  = or_oc;
        return res;
    endfunction

    // Present one box after a random gap (none while no_idle is set) and record its verdict once it is taken.
    task automatic send_box(input box_t b, input bit typed, input cull_result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        min_x <= b.min_x;
        min_y <= b.min_y;
        min_z <= b.min_z;
        max_x <= b.max_x;
        max_y <= b.max_y;
        max_z <= b.max_z;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        awaited_verdicts.push_back(typed ? want : cull_box(view_proj, b));
        boxes_sent++;
    endtask

    // Stop issuing boxes and let the pipeline empty before touching the matrix.
    task automatic wait_idle();
        start <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Write all four matrix rows back to back over the register port.
    task automatic load_matrix(input matrix_t m);
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_BITS'(i << REG_SEL_LSB);
            pwdata  <= m[i];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            view_proj[i] = m[i];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        matrix_loads++;
    endtask

    // Compare each result against the oldest outstanding verdict.
    always @(posedge clk)
    begin
        cull_result_t want;
        if (rst_n && done)
        begin
            if (awaited_verdicts.size() == 0)
            begin
                $display("%0t: result with no box outstanding: verdict %0d, and %h, or %h",
                         $time, verdict, common_outcode, union_outcode);
                mismatches++;
            end
            else
            begin
                want = awaited_verdicts.pop_front();
                results_checked++;
                if (verdict !== want.verdict)
                begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, want.verdict, verdict);
                    mismatches++;
                end
                if (common_outcode !== want.common_oc)
                begin
                    $display("%0t: common_outcode mismatch: expected %h, actual %h",
                             $time, want.common_oc, common_outcode);
                    mismatches++;
                end
                if (union_outcode !== want.union_oc)
                begin
                    $display("%0t: union_outcode mismatch: expected %h, actual %h",
                             $time, want.union_oc, union_outcode);
                    mismatches++;
                end
            end
            case (verdict)
                VERDICT_INSIDE:  inside_seen++;
                VERDICT_OUTSIDE: outside_seen++;
                VERDICT_PARTIAL: partial_seen++;
                default: ;
            endcase
        end
    end

    // Watchdog: end the run if no box, result or register write moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, awaited_verdicts.size());
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases.
    initial
    begin
        box_t        b;
        matrix_t     mat;
        logic [15:0] coef;
        int          mode;
        int          shape;
        int          ax;
        int          tmp;
        int          lo_c [3];
        int          hi_c [3];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; a matrix load drains the pipeline first.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (directed_rows[i].load)
            begin
                wait_idle();
                load_matrix(directed_rows[i].mat);
            end
            send_box(directed_rows[i].box, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under a fresh matrix of one of four styles.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            mode = ph % 4;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    case (mode)
                        0: coef = 16'($urandom);
                        1:
                        begin
                            // Scaled diagonal with a non-negative w and a near-plane offset.
                            if (r == c && r < NUM_AXES)
                            begin
                                coef = 16'($urandom_range(256, 4096));
                                if ($urandom_range(0, 1) == 1)
                                    coef = -coef;
                            end
                            else if (r == ROW_W && c == 3)
                                coef = 16'($urandom_range(0, 32767));
                            else if (r == ROW_Z && c == 3)
                                coef = 16'(int'($urandom_range(0, 8192)) - 4096);
                            else
                                coef = '0;
                        end
                        2: coef = 16'(int'($urandom_range(0, 8192)) - 4096);
                        default: coef = EXTREME_COEFS[$urandom_range(0, 4)];
                    endcase
                    mat[r][COEF_BITS*c +: COEF_BITS] = coef;
                end
            end
            wait_idle();
            load_matrix(mat);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 31) == 0)
                    no_idle = !no_idle;
                // Mostly small boxes near the origin, some full-range and extreme ones.
                shape = $urandom_range(0, 9);
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if (shape < 7)
                    begin
                        lo_c[a] = int'($urandom_range(0, 96)) - 48;
                        hi_c[a] = lo_c[a] + int'($urandom_range(0, 12));
                    end
                    else if (shape < 9)
                    begin
                        lo_c[a] = int'($urandom_range(0, 65535)) - 32768;
                        hi_c[a] = int'($urandom_range(0, 65535)) - 32768;
                    end
                    else
                    begin
                        lo_c[a] = EXTREME_COORDS[$urandom_range(0, 4)];
                        hi_c[a] = EXTREME_COORDS[$urandom_range(0, 4)];
                    end
                end
                // Occasionally give an axis its minimum above its maximum.
                if ($urandom_range(0, 9) == 0)
                begin
                    ax       = $urandom_range(0, 2);
                    tmp      = lo_c[ax];
                    lo_c[ax] = hi_c[ax];
                    hi_c[ax] = tmp;
                end
                b.min_x = coord_t'(lo_c[0]);
                b.min_y = coord_t'(lo_c[1]);
                b.min_z = coord_t'(lo_c[2]);
                b.max_x = coord_t'(hi_c[0]);
                b.max_y = coord_t'(hi_c[1]);
                b.max_z = coord_t'(hi_c[2]);
                send_box(b, 1'b0, '0);
            end
        end

        wait_idle();
        $display("testbench: %0d boxes over %0d matrix loads, %0d results checked",
                 boxes_sent, matrix_loads, results_checked);
        $display("testbench: verdicts seen: %0d inside, %0d outside, %0d partial",
                 inside_seen, outside_seen, partial_seen);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/acull_pkg.sv
hdl/acull_cfg.sv
hdl/acull_mul.sv
hdl/acull_sum.sv
hdl/acull_code.sv
hdl/acull_merge.sv
hdl/aabb_frustum_cull.sv
dv/testbench.sv
